// ===== rtl/udpcs_pkg.sv =====
// Package for the UDP checksum block: the per-byte operation code, the queue
// entry type, frame offsets and the one's complement add. No dependencies.
package udpcs_pkg;

    // Default limit on counted frame bytes.
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Width used for comparing positions against segment bounds.
    localparam int CMP_W = 18;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Frame offsets.
    localparam int POS_PROTOCOL  = 23;
    localparam int POS_SRC_IP    = 26;
    localparam int POS_UDP       = 34;
    localparam int POS_UDP_LEN   = 38;
    localparam int POS_PAYLOAD   = 42;
    localparam int UDP_HDR_BYTES = 8;

    // What the back does with one byte.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,  // byte is not summed
        OP_ADD_LOW   = 3'd1,  // add byte as a word with a zero high byte
        OP_HOLD      = 3'd2,  // keep byte as high byte of the next word
        OP_ADD_PAIR  = 3'd3,  // add held byte and this byte as one word
        OP_ADD_TWICE = 3'd4,  // as above, twice (UDP length word)
        OP_ADD_HIGH  = 3'd5   // odd final byte, padded with a zero low byte
    } udpcs_op_t;

    typedef struct packed {
        udpcs_op_t   op;
        logic [7:0]  data;
        logic        last;
        logic        bad;
    } udpcs_entry_t;

    // One's complement add with end-around carry folded once.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/udp_checksum_from_frame_top.sv =====
// Top level of the UDP checksum block; instantiates udpcs_front, udpcs_queue
// and udpcs_back, and uses udpcs_pkg.
// Throughput: one frame byte per cycle with no gap between frames while result items are
// taken; a waiting result stalls the back at the next last byte, and s_tready drops once
// the four-entry queue has filled behind it.
// Result path: the last byte is written into the queue, popped by the back and then
// stored in the result register, whose valid flag drives m_tvalid.
// Reset: rst_n is asynchronous and active low; it clears the position, the UDP length,
// the running sum, the queue and the result valid flag.
module udp_checksum_from_frame_top #(
    parameter int MAX_FRAME_BYTES = udpcs_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: one frame byte per item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // frame_last
    // Result stream: one item per frame.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] checksum_value
    output logic        m_tuser    // [0] malformed
);

    // The front classifies each byte as it is accepted and pushes it into the
    // queue; the back pops the queue and updates the sum. The queue lets the
    // input keep flowing while a finished result waits for the consumer.

    logic                    accept;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_head_valid;
    udpcs_pkg::udpcs_entry_t front_entry;
    udpcs_pkg::udpcs_entry_t q_head_entry;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    udpcs_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (s_tdata),
        .frame_last (s_tlast),
        .entry      (front_entry)
    );

    udpcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    udpcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_entry   (q_head_entry),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_checksum (m_tdata),
        .out_bad      (m_tuser)
    );

endmodule

// ===== rtl/udpcs_front.sv =====
// Front part of the UDP checksum block: tracks the byte position and the UDP
// length, classifies each byte and flags malformed frames. Uses udpcs_pkg.
module udpcs_front #(
    parameter int MAX_FRAME_BYTES = udpcs_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_last,
    output udpcs_pkg::udpcs_entry_t entry
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW    = udpcs_pkg::CMP_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      udp_len_reg, udp_len_next;

    logic [15:0]      len_now;
    logic             in_range;
    logic [CW-1:0]    p_ext;
    logic [CW-1:0]    seg_stop;
    logic [CW-1:0]    seg_end;
    logic             bad;
    udpcs_pkg::udpcs_op_t op;

    assign p_ext    = {{(CW-POS_W){1'b0}}, pos_reg};
    assign in_range = p_ext < CW'(MAX_FRAME_BYTES);

    always_comb
    begin
        if (pos_reg == POS_W'(udpcs_pkg::POS_UDP_LEN))
            len_now = {frame_byte, 8'h00};
        else if (pos_reg == POS_W'(udpcs_pkg::POS_UDP_LEN + 1))
            len_now = {udp_len_reg[15:8], frame_byte};
        else
            len_now = udp_len_reg;
    end

    // One past the final UDP byte, and the final UDP byte itself.
    assign seg_stop = {{(CW-16){1'b0}}, udp_len_reg} + CW'(udpcs_pkg::POS_UDP);
    assign seg_end  = {{(CW-16){1'b0}}, len_now} + CW'(udpcs_pkg::POS_UDP - 1);

    always_comb
    begin
        op = udpcs_pkg::OP_NONE;
        if (in_range)
        begin
            priority if (pos_reg == POS_W'(udpcs_pkg::POS_PROTOCOL))
                op = udpcs_pkg::OP_ADD_LOW;
            else if (pos_reg >= POS_W'(udpcs_pkg::POS_SRC_IP) &&
                     pos_reg <  POS_W'(udpcs_pkg::POS_PAYLOAD))
            begin
                if (!pos_reg[0])
                    op = udpcs_pkg::OP_HOLD;
                else if (pos_reg == POS_W'(udpcs_pkg::POS_UDP_LEN + 1))
                    op = udpcs_pkg::OP_ADD_TWICE;
                else
                    op = udpcs_pkg::OP_ADD_PAIR;
            end
            else if (pos_reg >= POS_W'(udpcs_pkg::POS_PAYLOAD) && p_ext < seg_stop)
            begin
                if (pos_reg[0])
                    op = udpcs_pkg::OP_ADD_PAIR;
                else if (p_ext + CW'(1) == seg_stop)
                    op = udpcs_pkg::OP_ADD_HIGH;
                else
                    op = udpcs_pkg::OP_HOLD;
            end
            else
                op = udpcs_pkg::OP_NONE;
        end
    end

    assign bad = (pos_reg < POS_W'(udpcs_pkg::POS_UDP_LEN + 1)) ||
                 (len_now < 16'(udpcs_pkg::UDP_HDR_BYTES)) ||
                 (p_ext < seg_end) ||
                 (seg_end >= CW'(MAX_FRAME_BYTES));

    assign entry.op   = op;
    assign entry.data = frame_byte;
    assign entry.last = frame_last;
    assign entry.bad  = bad;

    always_comb
    begin
        pos_next     = pos_reg;
        udp_len_next = udp_len_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                pos_next     = '0;
                udp_len_next = '0;
            end
            else
            begin
                if (in_range)
                    pos_next = pos_reg + POS_W'(1);
                udp_len_next = len_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            udp_len_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            udp_len_reg <= udp_len_next;
        end
    end

endmodule

// ===== rtl/udpcs_queue.sv =====
// Short queue of classified bytes between the front and the back of the UDP
// checksum block. Uses udpcs_pkg for the entry type and depth.
module udpcs_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  udpcs_pkg::udpcs_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output udpcs_pkg::udpcs_entry_t head_entry
);

    localparam int DEPTH = udpcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    udpcs_pkg::udpcs_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (PTR_W+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/udpcs_back.sv =====
// Back part of the UDP checksum block: keeps the running one's complement sum,
// carries out each byte's operation and holds the result. Uses udpcs_pkg.
module udpcs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  udpcs_pkg::udpcs_entry_t head_entry,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             out_checksum,
    output logic                    out_bad
);

    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_checksum_reg, out_checksum_next;
    logic        out_bad_reg, out_bad_next;

    logic [15:0] pair_word;
    logic [15:0] pair_once;
    logic [15:0] sum_after;

    // A last byte needs the result register free (or being emptied now).
    assign pop = head_valid && (!head_entry.last || !out_valid_reg || out_ready);

    assign pair_word = {held_reg, head_entry.data};
    assign pair_once = udpcs_pkg::oc_add(sum_reg, pair_word);

    always_comb
    begin
        sum_after = sum_reg;
        held_next = held_reg;
        unique case (head_entry.op)
            udpcs_pkg::OP_NONE:      sum_after = sum_reg;
            udpcs_pkg::OP_ADD_LOW:   sum_after = udpcs_pkg::oc_add(sum_reg,
                                                 {8'h00, head_entry.data});
            udpcs_pkg::OP_HOLD:      held_next = head_entry.data;
            udpcs_pkg::OP_ADD_PAIR:  sum_after = pair_once;
            udpcs_pkg::OP_ADD_TWICE: sum_after = udpcs_pkg::oc_add(pair_once, pair_word);
            udpcs_pkg::OP_ADD_HIGH:
            begin
                held_next = head_entry.data;
                sum_after = udpcs_pkg::oc_add(sum_reg, {head_entry.data, 8'h00});
            end
            default:                 sum_after = sum_reg;
        endcase

        sum_next          = sum_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_checksum_next = out_checksum_reg;
        out_bad_next      = out_bad_reg;
        if (pop)
        begin
            sum_next = sum_after;
            if (head_entry.last)
            begin
                sum_next          = '0;
                held_next         = '0;
                out_valid_next    = 1'b1;
                out_checksum_next = ~sum_after;
                out_bad_next      = head_entry.bad;
            end
        end
        else
        begin
            held_next = held_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_checksum = out_checksum_reg;
    assign out_bad      = out_bad_reg;

    always_ff @(posedge clk)
    begin
        out_checksum_reg <= out_checksum_next;
        out_bad_reg      <= out_bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
